/* rtl/core/esdk_pkg.sv */
package esdk_pkg;
    localparam int MAX_ITEMS_DEF = 16;
    localparam int KEY_BITS_DEF  = 64;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    function automatic logic [63:0] order_rank(input logic [63:0] k);
        order_rank = k[63] ? ~k : (k | {1'b1, 63'd0});
    endfunction
endpackage

/* rtl/core/exchange_sort_double_keys_unit.sv */
// Sorter for sets of double keys, ascending by a total order on bit patterns
// (-0 below +0). Input beats on s_valid/s_ready carry s_key and s_last;
// s_last closes a set. Keys enter a chain of MAX_ITEMS compare cells, one
// beat per cycle while loading; each cell compares the incoming key with its
// own and, where the new key is smaller or the cell is empty, takes its left
// neighbor's key or the new key. Beats beyond capacity are discarded. After the
// closing beat the chain shifts out left, one result beat per cycle on
// m_valid/m_ready while m_ready is high, m_end_of_set on the final key,
// m_dropped on every key of a set that lost beats beyond capacity. The first
// result is offered in the cycle after the closing beat. Input is refused
// while a set drains, so a new set cannot enter before the last one has
// drained. A stalled receiver freezes the chain.
// Reset (aresetn low, synchronous) empties the chain and clears counts.
module exchange_sort_double_keys_unit #(
    parameter int MAX_ITEMS = esdk_pkg::MAX_ITEMS_DEF,
    parameter int KEY_BITS  = esdk_pkg::KEY_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KEY_BITS-1:0] s_key,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [KEY_BITS-1:0] m_sorted_key,
    output logic                m_end_of_set,
    output logic                m_dropped
);
    import esdk_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    cell_ctl_t       ctl;
    logic            s_acc, m_acc;

    logic [KEY_BITS-1:0] kout [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] occ;
    logic [MAX_ITEMS-1:0] take;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    genvar g;
    for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
        assign occ[g] = (cnt_reg > CW'(g));
        esdk_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .occ_in    (cnt_reg >= CW'(g)),
            .new_key   (s_key),
            .occ_here  (occ[g]),
            .prev_take ((g == 0) ? 1'b0 : take[(g + MAX_ITEMS - 1) % MAX_ITEMS]),
            .prev_key  (kout[(g + MAX_ITEMS - 1) % MAX_ITEMS]),
            .next_key  ((g == MAX_ITEMS - 1) ? kout[g] : kout[(g + 1) % MAX_ITEMS]),
            .key_out   (kout[g]),
            .take_out  (take[g])
        );
    end

    assign m_sorted_key = kout[0];
    assign m_end_of_set = (cnt_reg == CW'(1));
    assign m_dropped    = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready  = 1'b1;
                ctl.load = s_acc && (cnt_reg < CW'(MAX_ITEMS));
                if (s_acc) begin
                    if (cnt_reg < CW'(MAX_ITEMS)) begin
                        cnt_next = cnt_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                m_valid   = 1'b1;
                ctl.shift = m_acc;
                if (m_acc) begin
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_next = ST_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("load and drain overlap");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_ITEMS)) else $error("fill count overrun");
    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cnt_reg != '0) else $error("drain with empty chain");
    a_end_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_end_of_set) |=> (s_ready && !ovf_reg))
        else $error("set not closed after final beat");
endmodule

/* rtl/core/esdk_cell.sv */
module esdk_cell #(
    parameter int KEY_BITS = esdk_pkg::KEY_BITS_DEF
) (
    input  logic                  aclk,
    input  esdk_pkg::cell_ctl_t   ctl,
    input  logic                  occ_in,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic                  occ_here,
    input  logic                  prev_take,
    input  logic [KEY_BITS-1:0]   prev_key,
    input  logic [KEY_BITS-1:0]   next_key,
    output logic [KEY_BITS-1:0]   key_out,
    output logic                  take_out
);
    import esdk_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic                take_new;

    // load: new key lands in the first empty cell or first cell holding a larger key,
    // larger keys move one cell right
    assign take_new = !occ_here || (order_rank(new_key) < order_rank(key_reg));
    assign key_out  = key_reg;
    assign take_out = take_new;

    always_ff @(posedge aclk) begin
        if (ctl.load && occ_in) begin
            if (take_new) begin
                key_reg <= prev_take ? prev_key : new_key;
            end
        end else if (ctl.shift) begin
            key_reg <= next_key;
        end
    end
endmodule

/* tb/tb_exchange_sort_double_keys_unit.sv */
module tb_exchange_sort_double_keys_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = esdk_pkg::MAX_ITEMS_DEF;

    typedef struct packed {
        logic [63:0] key;
        logic        last;
    } key_beat_t;

    typedef struct packed {
        logic [63:0] key;
        logic        eos;
        logic        drop;
    } sorted_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_key = '0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_sorted_key;
    logic        m_end_of_set;
    logic        m_dropped;

    key_beat_t    pending_q[$];
    sorted_beat_t sorted_q[$];
    logic [63:0]  set_keys[$];
    bit           set_over;
    int           errors = 0;
    int           n_in = 0;
    int           n_out = 0;
    int           n_sets = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_mode = 0;
    bit           stim_done = 0;

    exchange_sort_double_keys_unit u_top (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [63:0] total_rank(input logic [63:0] k);
        return k[63] ? ~k : {1'b1, k[62:0]};
    endfunction

    // predictor: collect a set, sort on close, queue the sorted beats
    task automatic absorb_key(input key_beat_t b);
        logic [63:0] t;
        int n;
        if (set_keys.size() < CAP) set_keys.push_back(b.key);
        else set_over = 1;
        if (b.last) begin
            n = set_keys.size();
            for (int i = 0; i + 1 < n; i++)
                for (int j = i + 1; j < n; j++)
                    if (total_rank(set_keys[i]) > total_rank(set_keys[j])) begin
                        t = set_keys[i];
                        set_keys[i] = set_keys[j];
                        set_keys[j] = t;
                    end
            for (int k = 0; k < n; k++)
                sorted_q.push_back('{set_keys[k], k == n - 1, set_over});
            set_keys.delete();
            set_over = 0;
            n_sets++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h (beat %0d)", what, got, want, n_out);
        errors++;
    endtask

    task automatic add_set(input int n, input int style);
        logic [63:0] k;
        for (int i = 0; i < n; i++) begin
            k = {$urandom, $urandom};
            case (style)
                1: k[62:52] = 11'(11'h3ff + $urandom_range(0, 6) - 3);
                2: k = {$urandom_range(0, 1) == 1, 63'($urandom_range(0, 3))};
                default: ;
            endcase
            pending_q.push_back('{k, i == n - 1});
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                absorb_key('{s_key, s_last});
                n_in++;
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    {s_key, s_last} <= pending_q.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                    stim_done <= 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        sorted_beat_t w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (sorted_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_sorted_key, '0);
                end else begin
                    w = sorted_q.pop_front();
                    if (m_sorted_key !== w.key) report_mismatch("key", m_sorted_key, w.key);
                    if (m_end_of_set !== w.eos)
                        report_mismatch("end_of_set", 64'(m_end_of_set), 64'(w.eos));
                    if (m_dropped !== w.drop)
                        report_mismatch("dropped", 64'(m_dropped), 64'(w.drop));
                end
                n_out++;
            end
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= ($urandom_range(0, 7) != 0);
                default: m_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    initial begin
        pending_q.push_back('{64'h0, 1'b1});
        pending_q.push_back('{64'hffff_ffff_ffff_ffff, 1'b1});
        pending_q.push_back('{64'h0000_0000_0000_0000, 1'b0});
        pending_q.push_back('{64'h8000_0000_0000_0000, 1'b0});
        pending_q.push_back('{64'h7ff0_0000_0000_0000, 1'b0});
        pending_q.push_back('{64'hfff0_0000_0000_0000, 1'b0});
        pending_q.push_back('{64'h7ff8_0000_0000_0001, 1'b0});
        pending_q.push_back('{64'hfff8_0000_0000_0001, 1'b0});
        pending_q.push_back('{64'h3ff0_0000_0000_0000, 1'b0});
        pending_q.push_back('{64'h3ff0_0000_0000_0000, 1'b0});
        pending_q.push_back('{64'h0000_0000_0000_0001, 1'b0});
        pending_q.push_back('{64'h8000_0000_0000_0001, 1'b1});
        add_set(CAP + 3, 0);
        while (pending_q.size() < 370) begin
            case ($urandom_range(0, 9))
                0: add_set(CAP + $urandom_range(1, 4), $urandom_range(0, 2));
                1: add_set(CAP, $urandom_range(0, 2));
                default: add_set($urandom_range(1, 8), $urandom_range(0, 2));
            endcase
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done && sorted_q.size() == 0);
        repeat (2 * CAP + 20) @(posedge aclk);
        $display("sorted %0d sets: %0d keys in, %0d keys out", n_sets, n_in, n_out);
        if (errors == 0 && sorted_q.size() == 0 && set_keys.size() == 0)
            $display("tb_exchange_sort_double_keys_unit: done, clean");
        else
            $display("tb_exchange_sort_double_keys_unit: done, errors");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_exchange_sort_double_keys_unit: done, errors");
        $finish;
    end
endmodule
